// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
// depends on nothing; take in by include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define ASSERT_IMPLIES(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("implication failed");

// next-cycle implication under an active-low reset
`define ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/lfid_pkg.sv =====
// shared types and constants for the lowest free id allocator
// depends on nothing
package lfid_pkg;

    // identifier and bitmap word geometry
    localparam int unsigned ID_W          = 13;
    localparam int unsigned WORD_W        = 64;
    localparam int unsigned WORD_AW       = 6;
    localparam int unsigned MAP_AW        = ID_W - WORD_AW;
    localparam int unsigned POOL_SIZE_DEF = 8192;

    // register reset values
    localparam logic [ID_W-1:0] FIRST_ID_RST = 13'd300;
    localparam logic [ID_W-1:0] LAST_ID_RST  = 13'd5000;

    // configuration register indexes
    localparam logic CFG_FIRST_ID = 1'b0;
    localparam logic CFG_LAST_ID  = 1'b1;

    // command codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_RANGE     = 2'd2
    } status_t;

    // request to the bitmap word memory
    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [MAP_AW-1:0] raddr;
    } map_req_t;

endpackage

// ===== rtl/lfid_map_ram.sv =====
// bitmap word memory: one write port, one registered read port
// depends on lfid_pkg
module lfid_map_ram
    import lfid_pkg::*;
#(
    parameter int unsigned DEPTH = POOL_SIZE_DEF / WORD_W
)
(
    input  logic              clk,
    input  map_req_t          req,
    output logic [WORD_W-1:0] rd_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lowest_free_id_allocator.sv =====
// lowest free id allocator: 64-bit bitmap words scanned one word per cycle
// allocate: scans until a free bit or the range's last word (1 .. NUM_WORDS words scanned)
// release: read-modify-write of one word; range errors skip the memory and go to S_DONE
// one transaction in flight; the next is taken once the result is registered
// after reset a clearing pass zeroes all NUM_WORDS map words (128 by default)
// depends on lfid_pkg and lfid_map_ram
module lowest_free_id_allocator
    import lfid_pkg::*;
#(
    parameter int unsigned POOL_SIZE = POOL_SIZE_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            command,
    input  logic [ID_W-1:0] release_id,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [ID_W-1:0] granted_id,
    output logic [1:0]      status,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [ID_W-1:0] cfg_data
);

    localparam int unsigned USED_IDS  = (POOL_SIZE < 2**ID_W) ? POOL_SIZE : 2**ID_W;
    localparam int unsigned NUM_WORDS = (USED_IDS + WORD_W - 1) / WORD_W;
    localparam logic [ID_W-1:0]   POOL_TOP  = ID_W'(USED_IDS - 1);
    localparam logic [MAP_AW-1:0] LAST_WORD = MAP_AW'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_REL,
        S_DONE
    } state_t;

    // lowest set bit of a bitmap word
    function automatic logic [WORD_AW-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [WORD_AW-1:0] idx;
        logic               hit;
        idx = '0;
        hit = 1'b0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (v[i] && !hit)
            begin
                idx = WORD_AW'(i);
                hit = 1'b1;
            end
        end
        return idx;
    endfunction

    state_t             state_reg;
    logic [ID_W-1:0]    first_id_reg;
    logic [ID_W-1:0]    last_id_reg;
    logic [MAP_AW-1:0]  ptr_reg;
    logic [MAP_AW-1:0]  start_word_reg;
    logic [MAP_AW-1:0]  end_word_reg;
    logic [WORD_AW-1:0] lo_bit_reg;
    logic [WORD_AW-1:0] hi_bit_reg;
    logic [WORD_AW-1:0] rel_bit_reg;
    logic [ID_W-1:0]    res_id_reg;
    status_t            res_st_reg;
    logic               out_valid_reg;
    logic [ID_W-1:0]    granted_id_reg;
    status_t            status_reg;

    logic [ID_W-1:0]    hi_id;
    logic               range_empty;
    logic               rel_ok;
    logic               in_take;
    logic               out_free;
    logic [WORD_W-1:0]  rd_data;
    logic [WORD_W-1:0]  lo_mask;
    logic [WORD_W-1:0]  hi_mask;
    logic [WORD_W-1:0]  avail;
    logic               found;
    logic [WORD_AW-1:0] free_bit;
    map_req_t           map_req;

    // usable range clipped to the pool
    assign hi_id       = (last_id_reg > POOL_TOP) ? POOL_TOP : last_id_reg;
    assign range_empty = first_id_reg > hi_id;
    assign rel_ok      = (release_id >= first_id_reg) && (release_id <= hi_id);

    // handshakes
    assign in_stall  = state_reg != S_IDLE;
    assign in_take   = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign granted_id = granted_id_reg;
    assign status     = status_reg;

    // free bits of the word under scan, limited to the range
    assign lo_mask  = (ptr_reg == start_word_reg) ?
                      ((WORD_W'(1) << lo_bit_reg) - WORD_W'(1)) : '0;
    assign hi_mask  = (ptr_reg == end_word_reg) ?
                      (({WORD_W{1'b1}} << hi_bit_reg) << 1) : '0;
    assign avail    = ~rd_data & ~lo_mask & ~hi_mask;
    assign found    = |avail;
    assign free_bit = lowest_set(avail);

    // memory requests
    always_comb
    begin
        map_req = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                map_req.we    = 1'b1;
                map_req.waddr = ptr_reg;
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (command == CMD_ALLOC)
                    begin
                        map_req.re    = !range_empty;
                        map_req.raddr = first_id_reg[ID_W-1:WORD_AW];
                    end
                    else
                    begin
                        map_req.re    = rel_ok;
                        map_req.raddr = release_id[ID_W-1:WORD_AW];
                    end
                end
            end
            S_ALLOC:
            begin
                if (found)
                begin
                    map_req.we    = 1'b1;
                    map_req.waddr = ptr_reg;
                    map_req.wdata = rd_data | (WORD_W'(1) << free_bit);
                end
                else if (ptr_reg != end_word_reg)
                begin
                    map_req.re    = 1'b1;
                    map_req.raddr = ptr_reg + MAP_AW'(1);
                end
            end
            S_REL:
            begin
                map_req.we    = 1'b1;
                map_req.waddr = ptr_reg;
                map_req.wdata = rd_data & ~(WORD_W'(1) << rel_bit_reg);
            end
            S_DONE:
            begin
                map_req = '0;
            end
            default:
            begin
                map_req = '0;
            end
        endcase
    end

    lfid_map_ram #(
        .DEPTH (NUM_WORDS)
    ) u_map (
        .clk     (clk),
        .req     (map_req),
        .rd_data (rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_id_reg <= FIRST_ID_RST;
            last_id_reg  <= LAST_ID_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST_ID: first_id_reg <= cfg_data;
                CFG_LAST_ID:  last_id_reg  <= cfg_data;
                default:      first_id_reg <= first_id_reg;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ptr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            start_word_reg <= '0;
            end_word_reg   <= '0;
            lo_bit_reg     <= '0;
            hi_bit_reg     <= '0;
            rel_bit_reg    <= '0;
            res_id_reg     <= '0;
            res_st_reg     <= STAT_OK;
            granted_id_reg <= '0;
            status_reg     <= STAT_OK;
        end
        else
        begin
            // result register: load a finished transaction or drop a taken one
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg  <= 1'b1;
                granted_id_reg <= res_id_reg;
                status_reg     <= res_st_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    ptr_reg <= ptr_reg + MAP_AW'(1);
                    if (ptr_reg == LAST_WORD)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        if (command == CMD_ALLOC)
                        begin
                            res_id_reg     <= '0;
                            ptr_reg        <= first_id_reg[ID_W-1:WORD_AW];
                            start_word_reg <= first_id_reg[ID_W-1:WORD_AW];
                            end_word_reg   <= hi_id[ID_W-1:WORD_AW];
                            lo_bit_reg     <= first_id_reg[WORD_AW-1:0];
                            hi_bit_reg     <= hi_id[WORD_AW-1:0];
                            if (range_empty)
                            begin
                                res_st_reg <= STAT_EXHAUSTED;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_ALLOC;
                            end
                        end
                        else
                        begin
                            ptr_reg     <= release_id[ID_W-1:WORD_AW];
                            rel_bit_reg <= release_id[WORD_AW-1:0];
                            if (rel_ok)
                            begin
                                res_id_reg <= release_id;
                                res_st_reg <= STAT_OK;
                                state_reg  <= S_REL;
                            end
                            else
                            begin
                                res_id_reg <= '0;
                                res_st_reg <= STAT_RANGE;
                                state_reg  <= S_DONE;
                            end
                        end
                    end
                end
                S_ALLOC:
                begin
                    if (found)
                    begin
                        res_id_reg <= {ptr_reg, free_bit};
                        res_st_reg <= STAT_OK;
                        state_reg  <= S_DONE;
                    end
                    else if (ptr_reg == end_word_reg)
                    begin
                        res_st_reg <= STAT_EXHAUSTED;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + MAP_AW'(1);
                    end
                end
                S_REL:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/lfid_checker.sv =====
// port-level checks for the lowest free id allocator, bound to the top level
// depends on lfid_pkg and assert_macros.svh
`include "assert_macros.svh"

module lfid_checker
    import lfid_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_stall,
    input logic            out_valid,
    input logic            out_stall,
    input logic [ID_W-1:0] granted_id,
    input logic [1:0]      status
);

    // a stalled result stays up
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // a stalled result keeps its payload
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(granted_id) && $stable(status))

    // one transaction at a time: busy right after an accept
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

    // only defined status codes leave the block
    `ASSERT_IMPLIES(a_status_code, clk, rst_n, out_valid, status != 2'd3)

    // error results carry a zero id
    `ASSERT_IMPLIES(a_error_zero, clk, rst_n, out_valid && status != STAT_OK, granted_id == '0)

endmodule

bind lowest_free_id_allocator lfid_checker u_lfid_checker (.*);

// ===== test/lowest_free_id_allocator_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the lowest free id allocator
// holds its own bitmap predictor; depends on lfid_pkg and the allocator rtl
module lowest_free_id_allocator_tb;
    import lfid_pkg::*;

    localparam int POOL          = POOL_SIZE_DEF;
    localparam int TOP_ID        = POOL - 1;
    localparam int HOLD_CYCLES   = 400;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int DRAIN_CYCLES  = 150;
    localparam int RANDOM_PHASES = 14;

    typedef struct {
        logic            cmd;
        logic [ID_W-1:0] id;
    } request_t;

    typedef struct {
        logic [ID_W-1:0] id;
        status_t         st;
    } grant_t;

    // dut connections, known from time zero
    logic            clk        = 1'b0;
    logic            rst_n      = 1'b0;
    logic            in_valid   = 1'b0;
    logic            in_stall;
    logic            command    = CMD_ALLOC;
    logic [ID_W-1:0] release_id = '0;
    logic            out_valid;
    logic            out_stall  = 1'b0;
    logic [ID_W-1:0] granted_id;
    logic [1:0]      status;
    logic            cfg_we     = 1'b0;
    logic            cfg_index  = CFG_FIRST_ID;
    logic [ID_W-1:0] cfg_data   = '0;

    // predictor state and configuration shadow
    bit              model_busy [POOL];
    int              model_first = FIRST_ID_RST;
    int              model_last  = LAST_ID_RST;

    request_t        request_queue [$];
    grant_t          expected_grants [$];
    int              sent_count    = 0;
    int              checked_count = 0;
    int              error_count   = 0;
    int              idle_cycles   = 0;

    lowest_free_id_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .release_id (release_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .granted_id (granted_id),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #6 clk = ~clk;

    // expected result of one request, updating the shadow bitmap
    function automatic grant_t predict_grant(input logic cmd, input logic [ID_W-1:0] rid);
        grant_t g;
        int     hi;
        int     i;
        g.id = '0;
        g.st = STAT_OK;
        if (cmd == CMD_ALLOC)
        begin
            hi   = (model_last > TOP_ID) ? TOP_ID : model_last;
            g.st = STAT_EXHAUSTED;
            for (i = model_first; i <= hi; i++)
            begin
                if (!model_busy[i])
                begin
                    model_busy[i] = 1'b1;
                    g.id = i[ID_W-1:0];
                    g.st = STAT_OK;
                    break;
                end
            end
        end
        else if (int'(rid) >= model_first && int'(rid) <= model_last && int'(rid) < POOL)
        begin
            model_busy[rid] = 1'b0;
            g.id = rid;
        end
        else
        begin
            g.st = STAT_RANGE;
        end
        return g;
    endfunction

    task automatic add_request(input logic cmd, input int rid);
        request_t r;
        r.cmd = cmd;
        r.id  = rid[ID_W-1:0];
        request_queue.push_back(r);
        sent_count++;
    endtask

    // block is idle once every queued transaction has come back
    task automatic wait_idle();
        while (checked_count != sent_count)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[ID_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_FIRST_ID)
            model_first = val;
        else
            model_last = val;
    endtask

    task automatic set_range(input int lo, input int hi);
        wait_idle();
        write_cfg(CFG_FIRST_ID, lo);
        write_cfg(CFG_LAST_ID, hi);
    endtask

    // one random phase: fresh range, then allocs, releases near the range base and noise
    task automatic random_phase(input int count);
        int lo;
        int hi;
        int win;
        int r;
        int n;
        case ($urandom_range(0, 9))
            0:       begin lo = 0; hi = TOP_ID; end
            1:       begin lo = $urandom_range(1, TOP_ID); hi = $urandom_range(0, lo - 1); end
            2:       begin lo = $urandom_range(TOP_ID - 40, TOP_ID); hi = TOP_ID; end
            3:       begin lo = 0; hi = $urandom_range(0, 40); end
            default:
            begin
                lo = $urandom_range(0, TOP_ID);
                hi = lo + $urandom_range(0, 60);
                if (hi > TOP_ID)
                    hi = TOP_ID;
            end
        endcase
        set_range(lo, hi);
        win = (hi - lo > 80) ? lo + 80 : hi;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                add_request(CMD_ALLOC, $urandom_range(0, TOP_ID));
            else if (r < 90 && hi >= lo)
                add_request(CMD_RELEASE, $urandom_range(lo, win));
            else
                add_request(CMD_RELEASE, $urandom_range(0, TOP_ID));
        end
    endtask

    // sender: bursts of random length separated by random gaps
    int gap_left   = 0;
    int burst_left = 0;

    always @(posedge clk)
    begin : request_driver
        request_t nxt;
        grant_t   g;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                g = predict_grant(command, release_id);
                expected_grants.push_back(g);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    nxt = request_queue.pop_front();
                    in_valid   <= 1'b1;
                    command    <= nxt.cmd;
                    release_id <= nxt.id;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off mid-run
    int  stall_mode = 0;
    int  mode_left  = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (!hold_done && checked_count >= 700)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 200);
                end
                else
                begin
                    mode_left--;
                end
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 9) < 3);
                    2:       out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // compare each result transaction against the oldest expected grant
    always @(posedge clk)
    begin : result_check
        grant_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            checked_count++;
            if (expected_grants.size() == 0)
            begin
                $display("%0t: unexpected result granted_id=%0d status=%0d",
                         $time, granted_id, status);
                error_count++;
            end
            else
            begin
                want = expected_grants.pop_front();
                if (granted_id !== want.id)
                begin
                    $display("%0t: granted_id expected %0d actual %0d",
                             $time, want.id, granted_id);
                    error_count++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.st, status);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, sent_count - checked_count);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset range 300..5000: lowest-first order, reuse, free and out-of-range releases
        add_request(CMD_ALLOC, 0);
        add_request(CMD_ALLOC, 0);
        add_request(CMD_ALLOC, 0);
        add_request(CMD_RELEASE, 301);
        add_request(CMD_ALLOC, 0);
        add_request(CMD_RELEASE, 4000);
        add_request(CMD_RELEASE, 299);
        add_request(CMD_RELEASE, 5001);
        add_request(CMD_RELEASE, 0);
        add_request(CMD_RELEASE, TOP_ID);
        add_request(CMD_ALLOC, TOP_ID);

        // single id at the top of the pool
        set_range(TOP_ID, TOP_ID);
        add_request(CMD_ALLOC, 0);
        add_request(CMD_ALLOC, 0);
        add_request(CMD_RELEASE, TOP_ID);
        add_request(CMD_RELEASE, TOP_ID - 1);

        // empty range
        set_range(10, 5);
        add_request(CMD_ALLOC, 0);
        add_request(CMD_RELEASE, 7);

        // small range at zero, run to exhaustion
        set_range(0, 3);
        repeat (5) add_request(CMD_ALLOC, 0);

        // range moved while ids stay busy
        set_range(2, 5);
        add_request(CMD_ALLOC, 0);
        add_request(CMD_RELEASE, 1);

        for (p = 0; p < RANDOM_PHASES; p++)
            random_phase($urandom_range(100, 160));

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_grants.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_grants.size());
            error_count++;
        end
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
